[src/fca_pkg.sv]
`default_nettype none
package fca_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADLEN  = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  localparam logic [1:0] REG_FAT_SECTORS  = 2'd0;
  localparam logic [1:0] REG_DATA_SECTORS = 2'd1;
  localparam int CFG_DATA_W = 16;
  localparam logic [7:0] TAIL_FULL = 8'hFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] link_index;
    logic [15:0] link_value;
    logic [26:0] file_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] first_sector;
    logic [15:0] read_value;
    logic [16:0] data_sector;
    logic        end_full;
    logic        end_partial;
    logic        group_dirty;
    logic [7:0]  tail_high;
    logic [7:0]  tail_low;
    logic [1:0]  tail_valid;
  } rsp_t;

endpackage
`default_nettype wire

[src/fat_chain_allocator_top.sv]
// channel | signals                        | direction
// request | req_valid_i req_stall_o req_i  | in
// result  | rsp_valid_o rsp_stall_i rsp_o  | out
// config  | cfg_we_i cfg_index_i cfg_data_i | in
// load and bad requests: result registered on acceptance; read: through S_RDW and S_OUT
// allocate: a walk, then a take pass, two link memory reads per sector
// the registered link table read sets the walk step
// reset clears dirty marks and control; link table holds no reset
// one request at a time; a stalled result blocks the next request
`default_nettype none
module fat_chain_allocator_top #(
  parameter int LINK_COUNT      = 65536,
  parameter int SECTOR_BYTES    = 1024,
  parameter int MAX_FAT_SECTORS = 128
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [0:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire fca_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output fca_pkg::rsp_t      rsp_o
);
  import fca_pkg::*;
  localparam int AW = $clog2(LINK_COUNT);

  logic [7:0]  fat_q;
  logic [15:0] data_q;
  logic        we;
  logic [AW-1:0] wa, ra;
  logic [15:0] wd, rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_q  <= 8'd128;
      data_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_FAT_SECTORS[0:0]) fat_q <= cfg_data_i[7:0];
      else data_q <= cfg_data_i;
    end
  end

  fca_ctrl #(.LINK_COUNT(LINK_COUNT), .SECTOR_BYTES(SECTOR_BYTES),
             .MAX_FAT_SECTORS(MAX_FAT_SECTORS), .AW(AW)) u_ctrl (
    .clk_i, .rst_ni, .fat_q_i(fat_q), .data_q_i(data_q),
    .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o,
    .mem_we_o(we), .mem_waddr_o(wa), .mem_wdata_o(wd),
    .mem_raddr_o(ra), .mem_rdata_i(rd)
  );

  fca_link_mem #(.AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );
endmodule
`default_nettype wire

[src/fca_link_mem.sv]
`default_nettype none
module fca_link_mem #(
  parameter int AW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [15:0]   rdata_o
);
  logic [15:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[src/fca_ctrl.sv]
`default_nettype none
module fca_ctrl #(
  parameter int LINK_COUNT      = 65536,
  parameter int SECTOR_BYTES    = 1024,
  parameter int MAX_FAT_SECTORS = 128,
  parameter int AW              = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     fat_q_i,
  input  wire logic [15:0]    data_q_i,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire fca_pkg::req_t  req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output fca_pkg::rsp_t       rsp_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [15:0]         mem_wdata_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  wire logic [15:0]    mem_rdata_i
);
  import fca_pkg::*;

  localparam int LPG   = SECTOR_BYTES / 2;
  localparam int GSH   = $clog2(LPG);
  localparam int GW    = (MAX_FAT_SECTORS > 1) ? $clog2(MAX_FAT_SECTORS) : 1;
  localparam int SSH   = $clog2(SECTOR_BYTES);
  localparam int NW    = 28 - SSH;

  typedef enum logic [3:0] {
    S_IDLE, S_RDW, S_RD, S_WALK, S_TAKE, S_HEAD, S_TAIL, S_W0, S_WT, S_OUT
  } state_e;

  state_e       state_q;
  req_t         req_q;
  rsp_t         rsp_q;
  logic         out_q;
  logic [NW-1:0] need_q, cnt_q;
  logic [15:0]  cur_q, first_q, head_q;
  logic [MAX_FAT_SECTORS-1:0] dirty_q;
  logic [SSH-1:0] rem_q;
  logic         we_q;
  logic [AW-1:0] wa_q, ra_q;
  logic [15:0]  wd_q;

  logic [7:0] fatc;
  assign fatc = (fat_q_i == 8'd0) ? 8'd1 : fat_q_i;

  function automatic logic addr_ok(input logic [15:0] i, input logic [7:0] f,
                                   input logic [15:0] d);
    logic [15:0] g;
    g = 16'(i >> GSH);
    return (32'(i) < LINK_COUNT) && (i <= d) && (g < 16'(f)) &&
           (32'(g) < MAX_FAT_SECTORS);
  endfunction

  function automatic logic [GW-1:0] grp(input logic [15:0] i);
    return GW'(i >> GSH);
  endfunction

  logic [16:0] sec;
  assign sec = 17'(req_q.link_index) + 17'(fatc) - 17'd1;

  logic [NW-1:0] need_d;
  assign need_d = NW'((28'(req_i.file_bytes) + 28'(SECTOR_BYTES - 1)) >> SSH);

  assign req_stall_o = (state_q != S_IDLE) || out_q;
  assign rsp_valid_o = out_q;
  assign rsp_o = rsp_q;
  assign mem_we_o = we_q;
  assign mem_waddr_o = wa_q;
  assign mem_wdata_o = wd_q;
  assign mem_raddr_o = ra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_q   <= 1'b0;
      dirty_q <= '0;
      we_q    <= 1'b0;
    end else begin
      we_q <= 1'b0;
      if (out_q && !rsp_stall_i) begin
        out_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && !req_stall_o) begin
            req_q <= req_i;
            rsp_q <= '0;
            rem_q <= req_i.file_bytes[SSH-1:0];
            need_q <= need_d;
            if (req_i.operation == OP_ALLOC) begin
              if (req_i.file_bytes == '0) begin
                rsp_q.status <= ST_BADLEN;
                out_q <= 1'b1;
              end else begin
                ra_q <= '0;
                cnt_q <= '0;
                state_q <= S_RD;
              end
            end else if (req_i.operation == OP_NONE ||
                         !addr_ok(req_i.link_index, fatc, data_q_i)) begin
              rsp_q.status <= ST_RANGE;
              out_q <= 1'b1;
            end else if (req_i.operation == OP_LOAD) begin
              we_q <= 1'b1;
              wa_q <= AW'(req_i.link_index);
              wd_q <= req_i.link_value;
              rsp_q.status <= ST_OK;
              out_q <= 1'b1;
            end else begin
              ra_q <= AW'(req_i.link_index);
              state_q <= S_RDW;
            end
          end
        end
        S_RDW: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          state_q <= S_IDLE;
          rsp_q.status <= ST_OK;
          rsp_q.read_value <= mem_rdata_i;
          rsp_q.data_sector <= sec;
          rsp_q.end_full <= (mem_rdata_i == 16'd0);
          rsp_q.end_partial <= (mem_rdata_i == req_q.link_index);
          rsp_q.group_dirty <= dirty_q[grp(req_q.link_index)];
          out_q <= 1'b1;
        end
        S_RD: begin
          state_q <= S_WALK;
        end
        S_WALK: begin
          // mem_rdata_i is link of ra_q
          if (cnt_q == need_q) begin
            ra_q <= '0;
            cnt_q <= '0;
            state_q <= S_TAKE;
          end else if (mem_rdata_i == 16'd0 ||
                       !addr_ok(mem_rdata_i, fatc, data_q_i)) begin
            rsp_q.status <= ST_NOSPACE;
            out_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            ra_q <= AW'(mem_rdata_i);
            cnt_q <= cnt_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_TAKE: begin
          state_q <= S_HEAD;
        end
        S_HEAD: begin
          if (cnt_q == need_q) begin
            cur_q <= 16'(ra_q);
            head_q <= mem_rdata_i;
            state_q <= S_W0;
          end else begin
            if (cnt_q == '0) first_q <= mem_rdata_i;
            ra_q <= AW'(mem_rdata_i);
            cnt_q <= cnt_q + 1'b1;
            state_q <= S_TAKE;
          end
        end
        S_W0: begin
          ra_q <= AW'(cur_q);
          state_q <= S_TAIL;
          we_q <= 1'b1;
          wa_q <= '0;
          wd_q <= head_q;
        end
        S_TAIL: begin
          state_q <= S_WT;
        end
        S_WT: begin
          logic [15:0] nv;
          nv = (rem_q == '0) ? 16'd0 : cur_q;
          if (head_q != first_q) dirty_q[0] <= 1'b1;
          if (mem_rdata_i != nv) dirty_q[grp(cur_q)] <= 1'b1;
          we_q <= 1'b1;
          wa_q <= AW'(cur_q);
          wd_q <= nv;
          if (rem_q == SSH'(SECTOR_BYTES - 1)) begin
            rsp_q.tail_high <= TAIL_FULL;
            rsp_q.tail_valid <= 2'd1;
          end else if (rem_q != '0) begin
            rsp_q.tail_high <= 8'(32'(rem_q) >> 8);
            rsp_q.tail_low <= rem_q[7:0];
            rsp_q.tail_valid <= 2'd3;
          end
          rsp_q.status <= ST_OK;
          rsp_q.first_sector <= 17'(first_q) + 17'(fatc) - 17'd1;
          out_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/fca_checker.sv]
`default_nettype none
module fca_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_stall_o,
  input wire fca_pkg::req_t req_i,
  input wire logic          rsp_valid_o,
  input wire logic          rsp_stall_i,
  input wire fca_pkg::rsp_t rsp_o
);
  import fca_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o)) else $error("rsp");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("busy");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o) else $error("one");
  a_badlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o && req_i.operation == OP_ALLOC &&
    req_i.file_bytes == '0 |=> rsp_valid_o && rsp_o.status == ST_BADLEN)
    else $error("len");
endmodule

bind fat_chain_allocator_top fca_checker u_chk (.*);
`default_nettype wire
